// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the calibrator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset
`define GSBC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same on the default clock and reset names
`define GSBC_ASSERT(lbl, prop, msg) `GSBC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/gsbc_pkg.sv -----
// Package for the gyro still-period bias calibrator: widths, field positions,
// register indexes, fixed-point constants and the iteration unit's control types.
// No dependencies.
package gsbc_pkg;

  // Sample counter width default and field widths
  localparam int COUNT_BITS_DEF = 16;
  localparam int GYRO_W         = 24;
  localparam int ACCEL_W        = 24;
  localparam int TEMP_W         = 16;
  localparam int TIME_W         = 32;
  localparam int LIMIT_W        = 23;
  localparam int GRAV_W         = 23;
  localparam int SQ_W           = 2 * ACCEL_W - 1;
  localparam int NORM_W         = 24;

  // Shared iteration unit: operand width, remainder width, square root steps
  localparam int OPND_W     = 48;
  localparam int ITER_W     = 27;
  localparam int SQRT_STEPS = 24;

  // Input tdata layout, lowest bit first
  localparam int IN_GYRO_LSB   = 0;
  localparam int IN_ACCEL_LSB  = 72;
  localparam int IN_TEMP_LSB   = 144;
  localparam int IN_HEATER_BIT = 160;
  localparam int IN_TIME_LSB   = 161;
  localparam int IN_TDATA_W    = 200;

  // Output tdata layout, lowest bit first
  localparam int OUT_CALIBRATING_BIT = 0;
  localparam int OUT_CALIBRATED_BIT  = 1;
  localparam int OUT_PAD_W           = 7;
  localparam int OUT_TDATA_W         = 104;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_MOVE_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_TOL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_TIME  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TGT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z     = 3'd7;

  // Register reset values
  localparam logic [LIMIT_W-1:0] MOVE_LIMIT_RST  = 23'd5719;
  localparam logic [LIMIT_W-1:0] ACCEL_TOL_RST   = 23'd32134;
  localparam logic [TEMP_W-1:0]  TARGET_TEMP_RST = 16'd10240;
  localparam logic [15:0]        STABLE_TIME_RST = 16'd1000;
  localparam logic [15:0]        SAMPLE_TGT_RST  = 16'd2000;

  // Fixed-point constants
  localparam int GRAVITY_Q16  = 642689;   // 9.80665 m/s2 in Q8.16
  localparam int TEMP_BAND_Q8 = 256;      // 1 degree C in Q8.8
  localparam int OFF_MAX      = 8388607;
  localparam int OFF_MIN      = -8388608;
  localparam int GRAV_MAX     = 8388607;

  // Iteration unit request and status
  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_sts_t;

endpackage

// ----- rtl/gsbc_sq.sv -----
// Registered squarer for one accel axis, reused across the three axes.
// Depends on gsbc_pkg.
module gsbc_sq (
  input  logic                           clk_i,
  input  logic [gsbc_pkg::ACCEL_W-1:0]   a_i,
  output logic [gsbc_pkg::SQ_W-1:0]      sq_o
);

  logic signed [2*gsbc_pkg::ACCEL_W-1:0] prod;

  // Square of a signed value is non-negative and at most 2^46
  assign prod = $signed(a_i) * $signed(a_i);

  always_ff @(posedge clk_i) begin
    sq_o <= prod[gsbc_pkg::SQ_W-1:0];
  end

endmodule

// ----- rtl/gsbc_iter.sv -----
// Shared trial-subtract unit: runs a floor square root (two bits a step) or an
// unsigned restoring division (one bit a step). Depends on gsbc_pkg.
module gsbc_iter #(
  parameter int COUNT_BITS = gsbc_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gsbc_pkg::iter_req_t           req_i,
  input  logic [gsbc_pkg::OPND_W-1:0]   operand_i,
  input  logic [COUNT_BITS-1:0]         divisor_i,
  output gsbc_pkg::iter_sts_t           sts_o,
  output logic [gsbc_pkg::OPND_W-1:0]   result_o
);

  localparam int OW        = gsbc_pkg::OPND_W;
  localparam int RW        = gsbc_pkg::ITER_W;
  localparam int DIV_STEPS = gsbc_pkg::GYRO_W + COUNT_BITS;
  localparam int PRE_SHIFT = OW - DIV_STEPS;
  localparam int CNT_W     = $clog2(OW + 1);

  logic             busy_q, done_q, sqrt_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RW-1:0]    rem_q, rem_sh, trial;
  logic [OW-1:0]    opnd_q, acc_q;
  logic [RW:0]      diff;
  logic             take;

  // One trial subtraction per cycle
  always_comb begin
    if (sqrt_q) begin
      rem_sh = {rem_q[RW-3:0], opnd_q[OW-1 -: 2]};
      trial  = RW'({acc_q[gsbc_pkg::SQRT_STEPS-1:0], 2'b01});
    end else begin
      rem_sh = {rem_q[RW-2:0], opnd_q[OW-1]};
      trial  = RW'(divisor_i);
    end
    diff = {1'b0, rem_sh} - {1'b0, trial};
    take = ~diff[RW];
  end

  // Step counter and handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sqrt_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        sqrt_q <= req_i.sqrt_mode;
        cnt_q  <= req_i.sqrt_mode ? CNT_W'(gsbc_pkg::SQRT_STEPS) : CNT_W'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder, operand and result shift registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      acc_q  <= '0;
      opnd_q <= req_i.sqrt_mode ? operand_i : (operand_i << PRE_SHIFT);
    end else if (busy_q) begin
      rem_q  <= take ? diff[RW-1:0] : rem_sh;
      acc_q  <= {acc_q[OW-2:0], take};
      opnd_q <= sqrt_q ? (opnd_q << 2) : (opnd_q << 1);
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign result_o   = acc_q;

endmodule

// ----- rtl/gyro_still_bias_calibrator_core.sv -----
// Top level of the gyro still-period bias calibrator: sequencer, state and
// registers. Depends on gsbc_pkg, gsbc_sq and gsbc_iter.
//
//  Channel   Dir  Handshake                 Payload
//  s_axis    in   s_axis_tvalid/tready      s_axis_tdata: one IMU sample
//  m_axis    out  m_axis_tvalid/tready      m_axis_tdata: status and latched values
//  cfg       in   cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// A sample passes through band check, three squares on the shared
// multiplier, 24 square root steps in the iteration unit, stillness check, output.
// The sample that completes calibration adds four divisions of 24+COUNT_BITS
// steps each on the same unit. s_axis_tready is high only between samples; a
// waiting result sits in the output register while the next sample is taken
// in. Reset needs no clearing pass.
module gyro_still_bias_calibrator_core #(
  parameter int COUNT_BITS = gsbc_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, temperature,
  // heater_settled, time_ms, zero pad
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [gsbc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // calibrating, calibrated, new_offset_x, new_offset_y, new_offset_z,
  // gravity_reference, zero pad
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [gsbc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [gsbc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gsbc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int GW    = gsbc_pkg::GYRO_W;
  localparam int SUM_W = gsbc_pkg::GYRO_W + COUNT_BITS;
  localparam int OFW   = SUM_W + 2;
  localparam int TW    = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int OW    = gsbc_pkg::OPND_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [OFW-1:0] OFF_MAX_W = OFW'(gsbc_pkg::OFF_MAX);
  localparam logic [OFW-1:0] OFF_MIN_W = OFW'(gsbc_pkg::OFF_MIN);

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_BAND  = 4'd1;
  localparam logic [3:0] ST_SQ0   = 4'd2;
  localparam logic [3:0] ST_SQ1   = 4'd3;
  localparam logic [3:0] ST_SQ2   = 4'd4;
  localparam logic [3:0] ST_SQ3   = 4'd5;
  localparam logic [3:0] ST_SQGO  = 4'd6;
  localparam logic [3:0] ST_SQWT  = 4'd7;
  localparam logic [3:0] ST_CHECK = 4'd8;
  localparam logic [3:0] ST_DIVGO = 4'd9;
  localparam logic [3:0] ST_DIVWT = 4'd10;
  localparam logic [3:0] ST_DIVPT = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;

  localparam logic [1:0] IDX_GRAV = 2'd3;

  // Configuration registers
  logic [gsbc_pkg::LIMIT_W-1:0] move_limit_q, accel_tol_q;
  logic [gsbc_pkg::TEMP_W-1:0]  target_temp_q;
  logic [15:0]                  stable_time_q, sample_tgt_q;
  logic [GW-1:0]                offset_q [3];

  // Captured sample
  logic [GW-1:0]                gyro_q  [3];
  logic [gsbc_pkg::ACCEL_W-1:0] accel_q [3];
  logic [gsbc_pkg::TEMP_W-1:0]  temp_q;
  logic                         heater_q;
  logic [gsbc_pkg::TIME_W-1:0]  time_q;

  // Calibration state
  logic [3:0]                   state_q, state_d;
  logic [SUM_W-1:0]             rate_sum_q [3];
  logic [SUM_W-1:0]             norm_sum_q;
  logic [COUNT_BITS-1:0]        still_cnt_q;
  logic [gsbc_pkg::TIME_W-1:0]  band_start_q;
  logic                         band_valid_q, accum_q, done_q;
  logic [GW-1:0]                lat_off_q [3];
  logic [gsbc_pkg::GRAV_W-1:0]  lat_grav_q;
  logic [1:0]                   div_idx_q;
  logic                         div_neg_q;
  logic [OW-1:0]                sumsq_q;
  logic                         m_valid_q;
  logic [gsbc_pkg::OUT_TDATA_W-1:0] m_data_q;

  // Shared units
  logic [gsbc_pkg::ACCEL_W-1:0] mul_a;
  logic [gsbc_pkg::SQ_W-1:0]    prod;
  gsbc_pkg::iter_req_t          iter_req;
  gsbc_pkg::iter_sts_t          iter_sts;
  logic [OW-1:0]                iter_opnd, iter_res;

  // Combinational helpers
  logic [16:0]                  temp_diff, temp_abs;
  logic                         in_band, settled;
  logic [gsbc_pkg::TIME_W-1:0]  band_ref, elapsed;
  logic [GW-1:0]                gyro_mag [3];
  logic                         move_fail, accel_fail, finish;
  logic [gsbc_pkg::NORM_W-1:0]  norm;
  logic [24:0]                  norm_dev, dev_abs;
  logic [COUNT_BITS-1:0]        count_inc;
  logic [TW-1:0]                target_cmp;
  logic [SUM_W-1:0]             src_sum, src_mag, dividend, quot;
  logic                         src_neg;
  logic [GW-1:0]                off_sel, off_sat;
  logic [OFW-1:0]               q_adj, off_diff;
  logic [gsbc_pkg::GRAV_W-1:0]  grav_sat;

  // Temperature band and band timing
  always_comb begin
    temp_diff = {temp_q[15], temp_q} - {target_temp_q[15], target_temp_q};
    temp_abs  = temp_diff[16] ? (~temp_diff + 17'd1) : temp_diff;
    in_band   = heater_q && (temp_abs <= 17'(gsbc_pkg::TEMP_BAND_Q8));
    band_ref  = band_valid_q ? band_start_q : time_q;
    elapsed   = time_q - band_ref;
    settled   = elapsed >= {16'd0, stable_time_q};
  end

  // Stillness test and still counter
  always_comb begin
    move_fail = 1'b0;
    for (int i = 0; i < 3; i++) begin
      gyro_mag[i] = gyro_q[i][GW-1] ? (~gyro_q[i] + GW'(1)) : gyro_q[i];
      if (gyro_mag[i] > {1'b0, move_limit_q}) move_fail = 1'b1;
    end
    norm       = iter_res[gsbc_pkg::NORM_W-1:0];
    norm_dev   = {1'b0, norm} - 25'(gsbc_pkg::GRAVITY_Q16);
    dev_abs    = norm_dev[24] ? (~norm_dev + 25'd1) : norm_dev;
    accel_fail = dev_abs > {2'b00, accel_tol_q};
    count_inc  = (still_cnt_q == COUNT_MAX) ? still_cnt_q : still_cnt_q + COUNT_BITS'(1);
    target_cmp = (TW'(sample_tgt_q) > TW'(COUNT_MAX)) ? TW'(COUNT_MAX) : TW'(sample_tgt_q);
    finish     = TW'(count_inc) >= target_cmp;
  end

  // Dividend for the mean: magnitude plus half the count
  always_comb begin
    case (div_idx_q)
      2'd0:    begin src_sum = rate_sum_q[0]; off_sel = offset_q[0]; end
      2'd1:    begin src_sum = rate_sum_q[1]; off_sel = offset_q[1]; end
      2'd2:    begin src_sum = rate_sum_q[2]; off_sel = offset_q[2]; end
      default: begin src_sum = norm_sum_q;    off_sel = offset_q[0]; end
    endcase
    src_neg  = (div_idx_q != IDX_GRAV) && src_sum[SUM_W-1];
    src_mag  = src_neg ? (~src_sum + SUM_W'(1)) : src_sum;
    dividend = src_mag + SUM_W'(still_cnt_q >> 1);
  end

  // New offset and gravity reference with saturation
  always_comb begin
    quot     = iter_res[SUM_W-1:0];
    q_adj    = div_neg_q ? (~{2'b00, quot} + OFW'(1)) : {2'b00, quot};
    off_diff = {{(OFW-GW){off_sel[GW-1]}}, off_sel} - q_adj;
    if ($signed(off_diff) > $signed(OFF_MAX_W)) begin
      off_sat = GW'(gsbc_pkg::OFF_MAX);
    end else if ($signed(off_diff) < $signed(OFF_MIN_W)) begin
      off_sat = GW'(gsbc_pkg::OFF_MIN);
    end else begin
      off_sat = off_diff[GW-1:0];
    end
    if (quot > SUM_W'(gsbc_pkg::GRAV_MAX)) begin
      grav_sat = gsbc_pkg::GRAV_W'(gsbc_pkg::GRAV_MAX);
    end else begin
      grav_sat = quot[gsbc_pkg::GRAV_W-1:0];
    end
  end

  // Shared unit control
  always_comb begin
    case (state_q)
      ST_SQ0:  mul_a = accel_q[0];
      ST_SQ1:  mul_a = accel_q[1];
      default: mul_a = accel_q[2];
    endcase
    iter_req.start     = ((state_q == ST_SQGO) || (state_q == ST_DIVGO)) && !iter_sts.busy;
    iter_req.sqrt_mode = (state_q == ST_SQGO);
    iter_opnd          = (state_q == ST_SQGO) ? sumsq_q : OW'(dividend);
  end

  gsbc_sq u_sq (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .sq_o  (prod)
  );

  gsbc_iter #(
    .COUNT_BITS (COUNT_BITS)
  ) u_iter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (iter_req),
    .operand_i (iter_opnd),
    .divisor_i (still_cnt_q),
    .sts_o     (iter_sts),
    .result_o  (iter_res)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = done_q ? ST_OUT : ST_BAND;
      ST_BAND:  state_d = (in_band && settled) ? ST_SQ0 : ST_OUT;
      ST_SQ0:   state_d = ST_SQ1;
      ST_SQ1:   state_d = ST_SQ2;
      ST_SQ2:   state_d = ST_SQ3;
      ST_SQ3:   state_d = ST_SQGO;
      ST_SQGO:  if (!iter_sts.busy) state_d = ST_SQWT;
      ST_SQWT:  if (iter_sts.done) state_d = ST_CHECK;
      ST_CHECK: state_d = (move_fail || accel_fail || !finish) ? ST_OUT : ST_DIVGO;
      ST_DIVGO: if (!iter_sts.busy) state_d = ST_DIVWT;
      ST_DIVWT: if (iter_sts.done) state_d = ST_DIVPT;
      ST_DIVPT: state_d = (div_idx_q == IDX_GRAV) ? ST_OUT : ST_DIVGO;
      ST_OUT:   if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_limit_q  <= gsbc_pkg::MOVE_LIMIT_RST;
      accel_tol_q   <= gsbc_pkg::ACCEL_TOL_RST;
      target_temp_q <= gsbc_pkg::TARGET_TEMP_RST;
      stable_time_q <= gsbc_pkg::STABLE_TIME_RST;
      sample_tgt_q  <= gsbc_pkg::SAMPLE_TGT_RST;
      offset_q[0]   <= '0;
      offset_q[1]   <= '0;
      offset_q[2]   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gsbc_pkg::REG_MOVE_LIMIT:  move_limit_q  <= cfg_wdata_i[gsbc_pkg::LIMIT_W-1:0];
        gsbc_pkg::REG_ACCEL_TOL:   accel_tol_q   <= cfg_wdata_i[gsbc_pkg::LIMIT_W-1:0];
        gsbc_pkg::REG_TARGET_TEMP: target_temp_q <= cfg_wdata_i[gsbc_pkg::TEMP_W-1:0];
        gsbc_pkg::REG_STABLE_TIME: stable_time_q <= cfg_wdata_i[15:0];
        gsbc_pkg::REG_SAMPLE_TGT:  sample_tgt_q  <= cfg_wdata_i[15:0];
        gsbc_pkg::REG_OFFSET_X:    offset_q[0]   <= cfg_wdata_i[GW-1:0];
        gsbc_pkg::REG_OFFSET_Y:    offset_q[1]   <= cfg_wdata_i[GW-1:0];
        gsbc_pkg::REG_OFFSET_Z:    offset_q[2]   <= cfg_wdata_i[GW-1:0];
        default: ;
      endcase
    end
  end

  // Sample capture, square sum and output data
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      for (int i = 0; i < 3; i++) begin
        gyro_q[i]  <= s_axis_tdata[gsbc_pkg::IN_GYRO_LSB + GW*i +: GW];
        accel_q[i] <= s_axis_tdata[gsbc_pkg::IN_ACCEL_LSB + gsbc_pkg::ACCEL_W*i +:
                                   gsbc_pkg::ACCEL_W];
      end
      temp_q   <= s_axis_tdata[gsbc_pkg::IN_TEMP_LSB +: gsbc_pkg::TEMP_W];
      heater_q <= s_axis_tdata[gsbc_pkg::IN_HEATER_BIT];
      time_q   <= s_axis_tdata[gsbc_pkg::IN_TIME_LSB +: gsbc_pkg::TIME_W];
    end
    case (state_q)
      ST_SQ1:   sumsq_q <= OW'(prod);
      ST_SQ2,
      ST_SQ3:   sumsq_q <= sumsq_q + OW'(prod);
      default: ;
    endcase
    if (state_q == ST_DIVGO) div_neg_q <= src_neg;
    if (state_q == ST_OUT && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {{gsbc_pkg::OUT_PAD_W{1'b0}}, lat_grav_q, lat_off_q[2], lat_off_q[1],
                   lat_off_q[0], done_q, accum_q};
    end
  end

  // Sequencer and calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rate_sum_q[0] <= '0;
      rate_sum_q[1] <= '0;
      rate_sum_q[2] <= '0;
      norm_sum_q   <= '0;
      still_cnt_q  <= '0;
      accum_q      <= 1'b0;
      band_start_q <= '0;
      band_valid_q <= 1'b0;
      done_q       <= 1'b0;
      lat_off_q[0] <= '0;
      lat_off_q[1] <= '0;
      lat_off_q[2] <= '0;
      lat_grav_q   <= '0;
      div_idx_q    <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      // Band tracking; leaving the band or a short dwell clears the sums
      if (state_q == ST_BAND) begin
        if (!in_band) begin
          band_valid_q <= 1'b0;
        end else begin
          band_start_q <= band_ref;
          band_valid_q <= 1'b1;
        end
        if (!in_band || !settled) begin
          rate_sum_q[0] <= '0;
          rate_sum_q[1] <= '0;
          rate_sum_q[2] <= '0;
          norm_sum_q    <= '0;
          still_cnt_q   <= '0;
          accum_q       <= 1'b0;
        end
      end

      // Still sample accumulates, motion clears
      if (state_q == ST_CHECK) begin
        if (move_fail || accel_fail) begin
          rate_sum_q[0] <= '0;
          rate_sum_q[1] <= '0;
          rate_sum_q[2] <= '0;
          norm_sum_q    <= '0;
          still_cnt_q   <= '0;
          accum_q       <= 1'b0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            rate_sum_q[i] <= rate_sum_q[i] + {{(SUM_W-GW){gyro_q[i][GW-1]}}, gyro_q[i]};
          end
          norm_sum_q  <= norm_sum_q + SUM_W'(norm);
          still_cnt_q <= count_inc;
          accum_q     <= 1'b1;
          div_idx_q   <= '0;
        end
      end

      // Latch one mean per division; the last one finishes calibration
      if (state_q == ST_DIVPT) begin
        case (div_idx_q)
          2'd0:    lat_off_q[0] <= off_sat;
          2'd1:    lat_off_q[1] <= off_sat;
          2'd2:    lat_off_q[2] <= off_sat;
          default: begin
            lat_grav_q    <= grav_sat;
            done_q        <= 1'b1;
            rate_sum_q[0] <= '0;
            rate_sum_q[1] <= '0;
            rate_sum_q[2] <= '0;
            norm_sum_q    <= '0;
            still_cnt_q   <= '0;
            accum_q       <= 1'b0;
          end
        endcase
        div_idx_q <= div_idx_q + 2'd1;
      end

      // Output register
      if (state_q == ST_OUT && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ----- rtl/gsbc_checker.sv -----
// Port-level checks for the calibrator top level, bound in below.
// Depends on gsbc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gsbc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [gsbc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // A stalled result request keeps its data
  `GSBC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")

  // One sample at a time: busy right after a request is taken
  `GSBC_ASSERT(a_busy_after_take, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input ready right after accept")

  // Accumulating and calibrated never shown together
  `GSBC_ASSERT(a_flags_excl, m_axis_tvalid |-> !(m_axis_tdata[gsbc_pkg::OUT_CALIBRATING_BIT] && m_axis_tdata[gsbc_pkg::OUT_CALIBRATED_BIT]), "calibrating and calibrated both set")

  // Calibrated is sticky across consecutive shown results
  `GSBC_ASSERT(a_cal_sticky, m_axis_tvalid && m_axis_tdata[gsbc_pkg::OUT_CALIBRATED_BIT] |=> !m_axis_tvalid || m_axis_tdata[gsbc_pkg::OUT_CALIBRATED_BIT], "calibrated flag dropped")

endmodule

bind gyro_still_bias_calibrator_core gsbc_checker u_gsbc_checker (.*);
